### src/crc32ws_pkg.sv
// Package: shared constants, types and the byte step of the CRC-32 core.
`default_nettype none
package crc32ws_pkg;

	localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
	localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;
	localparam int unsigned NUM_LANES    = 4;

	// Stage 1 control that travels with the lane results
	typedef struct packed {
		logic       last;
		logic [2:0] nbytes;
	} ctl_t;

	// Advance the reflected CRC register by one all-zero byte
	function automatic logic [31:0] crc_byte_step(input logic [31:0] r);
		logic [31:0] v;
		v = r;
		for (int k = 0; k < 8; k++) begin
			v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
		end
		return v;
	endfunction

endpackage
`default_nettype wire

### src/crc32_word_stream.sv
// Top level: Ethernet CRC-32 over a stream of 32-bit words, four byte lanes.
// Throughput: one item per cycle, any valid byte count, unless a last item waits on a stalled result.
// A last item is held in stage 1, then its CRC goes to the result register that drives m_tvalid.
// The loop that sets the rate is the CRC state register in the merge stage.
// Reset (arst_n low, asynchronous): inversion on, CRC at all ones, pipeline and result empty.
// A mode write reloads the CRC with the start value of the new mode.
`default_nettype none
module crc32_word_stream (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration: invert_enable
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,
	// input items
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] data_word
	input  wire logic [2:0]  s_tuser,   // [2:0] valid_bytes
	input  wire logic        s_tlast,   // last_word
	// result items
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata    // [31:0] crc_value
);

	logic                    s_fire;
	logic [2:0]              nbytes;
	logic [3:0][2:0]         lane_steps;
	logic [3:0][31:0]        lane_contrib;

	logic                    valid_s1;
	crc32ws_pkg::ctl_t       ctl_s1;
	logic [3:0][31:0]        lanes_s1;
	logic                    drain_s1;

	// clamp the byte count: anything above four counts as four
	assign nbytes = (s_tuser > 3'd4) ? 3'd4 : s_tuser;

	// lane i holds byte i (first byte at the top of the word); it is
	// followed by nbytes - i - 1 more bytes, so advance it nbytes - i times
	genvar gi;
	generate
		for (gi = 0; gi < crc32ws_pkg::NUM_LANES; gi++) begin : g_lane
			assign lane_steps[gi] = (nbytes > 3'(gi)) ? (nbytes - 3'(gi)) : 3'd0;

			crc32ws_lane u_lane (
				.data_byte (s_tdata[31 - 8*gi -: 8]),
				.steps     (lane_steps[gi]),
				.contrib   (lane_contrib[gi])
			);
		end
	endgenerate

	// Stage 1 drains every cycle, unless it holds a last item and the
	// result register is full and stalled; ordinary words never wait.
	assign drain_s1 = valid_s1 && (!ctl_s1.last || !m_tvalid || m_tready);
	assign s_tready = !valid_s1 || drain_s1;
	assign s_fire   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// lane results and control: load on accept, hold otherwise
	always_ff @(posedge clk) begin
		if (s_fire) begin
			lanes_s1      <= lane_contrib;
			ctl_s1.last   <= s_tlast;
			ctl_s1.nbytes <= nbytes;
		end
	end

	// combine lanes with the advanced state and emit on the last item
	crc32ws_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.advance   (drain_s1),
		.ctl       (ctl_s1),
		.lanes     (lanes_s1),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata)
	);

endmodule
`default_nettype wire

### src/crc32ws_lane.sv
// Byte lane: contribution of one message byte, advanced over the bytes after it.
`default_nettype none
module crc32ws_lane (
	input  wire logic [7:0]  data_byte,
	input  wire logic [2:0]  steps,
	output logic      [31:0] contrib
);

	logic [31:0] adv1, adv2, adv3, adv4;

	assign adv1 = crc32ws_pkg::crc_byte_step({24'd0, data_byte});
	assign adv2 = crc32ws_pkg::crc_byte_step(adv1);
	assign adv3 = crc32ws_pkg::crc_byte_step(adv2);
	assign adv4 = crc32ws_pkg::crc_byte_step(adv3);

	// zero steps: byte not valid in this item
	always_comb begin
		case (steps)
			3'd1:    contrib = adv1;
			3'd2:    contrib = adv2;
			3'd3:    contrib = adv3;
			3'd4:    contrib = adv4;
			default: contrib = '0;
		endcase
	end

endmodule
`default_nettype wire

### src/crc32ws_merge.sv
// Merge stage: CRC state register, lane combine and the result register.
`default_nettype none
module crc32ws_merge (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic                    cfg_wdata,
	input  wire logic                    advance,
	input  wire crc32ws_pkg::ctl_t       ctl,
	input  wire logic [3:0][31:0]        lanes,
	input  wire logic                    m_tready,
	output logic                         m_tvalid,
	output logic      [31:0]             m_tdata
);

	logic        inv_q;
	logic [31:0] crc_q;
	logic        out_valid_q;
	logic [31:0] out_data_q;
	logic [31:0] r1, r2, r3, r4;
	logic [31:0] crc_adv;
	logic [31:0] crc_next;
	logic [31:0] crc_final;

	assign r1 = crc32ws_pkg::crc_byte_step(crc_q);
	assign r2 = crc32ws_pkg::crc_byte_step(r1);
	assign r3 = crc32ws_pkg::crc_byte_step(r2);
	assign r4 = crc32ws_pkg::crc_byte_step(r3);

	always_comb begin
		case (ctl.nbytes)
			3'd1:    crc_adv = r1;
			3'd2:    crc_adv = r2;
			3'd3:    crc_adv = r3;
			3'd4:    crc_adv = r4;
			default: crc_adv = crc_q;
		endcase
	end

	assign crc_next  = crc_adv ^ lanes[0] ^ lanes[1] ^ lanes[2] ^ lanes[3];
	assign crc_final = crc_next ^ {32{inv_q}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q <= 1'b1;
			crc_q <= crc32ws_pkg::CRC_ALL_ONES;
		end else if (cfg_we) begin
			// reload the start value of the new mode
			inv_q <= cfg_wdata;
			crc_q <= {32{cfg_wdata}};
		end else if (advance) begin
			crc_q <= ctl.last ? {32{inv_q}} : crc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && ctl.last) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && ctl.last) begin
			out_data_q <= {crc_final[7:0], crc_final[15:8], crc_final[23:16], crc_final[31:24]};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule
`default_nettype wire

### src/crc32ws_check.sv
// Port checker for the CRC-32 word stream, bound to the top level.
`default_nettype none
module crc32ws_check (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        s_tlast,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata
);

	// a stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// input only backs up behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output back-pressure");

	// a fresh result always stems from a last item that was accepted into stage 1 before it
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
		else $error("result without a last item");

endmodule

bind crc32_word_stream crc32ws_check u_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

### dv/tb_top.sv
// Testbench for crc32_word_stream: queued word driver, CRC predictor and result checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  nbytes;
		logic        last;
		bit          drain_first;   // hold this item until no CRC is outstanding
	} word_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;

	word_item_t  word_queue[$];
	logic [31:0] crc_expected[$];
	int unsigned crc_pending_cnt = 0;   // mirrors crc_expected.size(), updated at the edge
	int unsigned sender_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned fail_count = 0;

	// running copy of the block's state and mode register
	logic        crc_mode_inv = 1'b1;
	logic [31:0] crc_state = 32'hFFFF_FFFF;

	crc32_word_stream dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	// Advance a reflected CRC by the top nbytes bytes of a word, low bit of each byte first
	function automatic logic [31:0] crc_absorb(input logic [31:0] acc, input logic [31:0] word,
			input logic [2:0] nbytes);
		logic [31:0] r;
		logic [7:0]  b;
		int          n;
		r = acc;
		n = (nbytes > 3'd4) ? 4 : int'(nbytes);
		for (int i = 0; i < n; i++) begin
			b = word[31 - 8 * i -: 8];
			for (int k = 0; k < 8; k++) begin
				if (r[0] ^ b[k])
					r = (r >> 1) ^ crc32ws_pkg::CRC_POLY;
				else
					r = r >> 1;
			end
		end
		return r;
	endfunction

	// Driver: offer the next item when the slot is free, idling at random
	always @(posedge clk) begin
		word_item_t nxt;
		logic       offer;
		if (!s_tvalid || s_tready) begin
			offer = 1'b0;
			if (arst_n && word_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				// a drain-first item waits until the bus is quiet and every CRC is back
				if (!word_queue[0].drain_first || (!s_tvalid && crc_pending_cnt == 0))
					offer = 1'b1;
			end
			if (offer) begin
				nxt = word_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= nxt.word;
				s_tuser  <= nxt.nbytes;
				s_tlast  <= nxt.last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Checker and predictor: compare results, track mode writes and accepted items
	always @(posedge clk) begin
		logic [31:0] want;
		logic [31:0] fin;
		int          pushed;
		int          popped;
		pushed = 0;
		popped = 0;
		if (m_tvalid && m_tready) begin
			if (crc_expected.size() == 0) begin
				report_mismatch($sformatf("unexpected CRC %08h", m_tdata));
			end else begin
				want = crc_expected.pop_front();
				popped = 1;
				if (m_tdata !== want)
					report_mismatch($sformatf("crc_value got %08h want %08h", m_tdata, want));
			end
		end
		if (cfg_we) begin
			// a mode write reloads the start value and drops any message in progress
			crc_mode_inv = cfg_wdata;
			crc_state = cfg_wdata ? crc32ws_pkg::CRC_ALL_ONES : 32'h0;
		end else if (s_tvalid && s_tready) begin
			crc_state = crc_absorb(crc_state, s_tdata, s_tuser);
			if (s_tlast) begin
				fin = crc_state ^ (crc_mode_inv ? crc32ws_pkg::CRC_ALL_ONES : 32'h0);
				crc_expected.push_back({fin[7:0], fin[15:8], fin[23:16], fin[31:24]});
				pushed = 1;
				crc_state = crc_mode_inv ? crc32ws_pkg::CRC_ALL_ONES : 32'h0;
			end
		end
		crc_pending_cnt <= crc_pending_cnt + pushed - popped;
		m_tready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic push_word(input logic [31:0] word, input logic [2:0] nbytes,
			input logic last, input bit drain_first = 1'b0);
		word_item_t it;
		it.word = word;
		it.nbytes = nbytes;
		it.last = last;
		it.drain_first = drain_first;
		word_queue.push_back(it);
	endtask

	// Wait until every item is taken and every CRC is back, then let the pipeline empty
	task automatic wait_quiet();
		@(negedge clk);
		while (word_queue.size() != 0 || s_tvalid || crc_pending_cnt != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_mode(input logic inv);
		wait_quiet();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= inv;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Random messages: mostly full words and a last word of one to four bytes, some malformed byte counts.
	// Stop at the item count even mid-message so the next mode write drops the tail.
	task automatic push_random_words(input int unsigned n_items);
		int unsigned done;
		int unsigned len;
		logic        last;
		logic [2:0]  nb;
		done = 0;
		while (done < n_items) begin
			len = $urandom_range(6, 1);
			for (int unsigned w = 0; w < len && done < n_items; w++) begin
				last = (w == len - 1);
				if ($urandom_range(9) == 0)
					nb = 3'($urandom_range(7));
				else if (last)
					nb = 3'($urandom_range(4, 1));
				else
					nb = 3'd4;
				push_word($urandom, nb, last);
				done++;
			end
		end
	endtask

	task automatic run_phase(input logic inv, input int unsigned idle, input int unsigned stall,
			input int unsigned n_items);
		write_mode(inv);
		sender_idle_pct = idle;
		recv_stall_pct  = stall;
		push_random_words(n_items);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, reset mode (inversion on), no idling
		push_word(32'h0000_0000, 3'd4, 1'b1);
		push_word(32'hFFFF_FFFF, 3'd4, 1'b1);
		push_word(32'hA1B2_C3D4, 3'd1, 1'b1);
		push_word(32'hA1B2_C3D4, 3'd2, 1'b1);
		push_word(32'hA1B2_C3D4, 3'd3, 1'b1);
		// the classic check string "123456789"
		push_word(32'h3132_3334, 3'd4, 1'b0);
		push_word(32'h3536_3738, 3'd4, 1'b0);
		push_word(32'h3900_0000, 3'd1, 1'b1);
		// no valid bytes: empty message, and an empty word inside a message
		push_word(32'hDEAD_BEEF, 3'd0, 1'b1);
		push_word(32'h1234_5678, 3'd0, 1'b0);
		push_word(32'h8765_4321, 3'd4, 1'b1);
		// too many valid bytes count as four
		push_word(32'h5555_AAAA, 3'd5, 1'b1);
		push_word(32'hAAAA_5555, 3'd6, 1'b1);
		push_word(32'h0F0F_F0F0, 3'd7, 1'b0);
		push_word(32'hF0F0_0F0F, 3'd2, 1'b1);
		// short word before the end of a message
		push_word(32'hCAFE_F00D, 3'd2, 1'b0);
		push_word(32'h0123_4567, 3'd3, 1'b0);
		push_word(32'h89AB_CDEF, 3'd4, 1'b1);
		// hold the sender until the pipeline has drained
		push_word(32'hA5A5_A5A5, 3'd4, 1'b1, 1'b1);
		push_word(32'h8000_0001, 3'd4, 1'b0);
		push_word(32'hFFFF_FFFF, 3'd3, 1'b1);
		// leave a message open: the next mode write drops it
		push_word(32'h7E7E_7E7E, 3'd4, 1'b0);

		run_phase(1'b0, 0, 0, 80);
		run_phase(1'b1, 87, 0, 80);
		run_phase(1'b0, 0, 87, 80);
		run_phase(1'b1, 36, 36, 80);
		run_phase(1'b0, 0, 0, 40);
		run_phase(1'b1, 0, 0, 40);

		wait_quiet();
		repeat (10) @(negedge clk);
		if (crc_expected.size() != 0)
			report_mismatch($sformatf("%0d CRC results never arrived", crc_expected.size()));
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#1ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule

### crc32_word_stream.f
src/crc32ws_pkg.sv
src/crc32ws_lane.sv
src/crc32ws_merge.sv
src/crc32_word_stream.sv
src/crc32ws_check.sv
dv/tb_top.sv
